// ===== rtl/core/cts_pkg.sv =====
// cts_pkg: shared types and constants for the cooperative task scheduler
// holds the slot record, the input and result words, and command/result codes
// no dependencies
package cts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
  localparam int DELAY_W    = 15;
  localparam int RUNS_W     = 8;
  localparam int DIV_W      = 16;

  localparam logic [1:0] CMD_OVERFLOW = 2'd0;
  localparam logic [1:0] CMD_ADD      = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_RUN      = 2'd2;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  typedef struct packed {
    logic [1:0]         command;
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] period;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] interval;
    logic [RUNS_W-1:0]  runs;
    logic [SLOT_W-1:0]  id;
  } slot_rec_t;

  // control from the sequencer to the row of cells
  typedef struct packed {
    logic               shift;
    slot_rec_t          head_rec;
    logic [DELAY_W-1:0] load_delay;
    logic [DELAY_W-1:0] load_interval;
  } ring_ctl_t;

endpackage

// ===== rtl/core/cts_cell.sv =====
// cts_cell: one task slot of the scheduler ring
// holds a slot record, loads it on add and takes its neighbor's record on shift
// depends on cts_pkg
module cts_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cts_pkg::SLOT_W-1:0]    home_id,
  input  cts_pkg::ring_ctl_t            ctl,
  input  logic                          load_en,
  input  cts_pkg::slot_rec_t            from_nbr,
  output cts_pkg::slot_rec_t            rec
);

  cts_pkg::slot_rec_t rec_r;
  cts_pkg::slot_rec_t rec_nxt;

  always_comb begin
    rec_nxt = rec_r;
    if (load_en) begin
      // ring is at its home position here, so keep runs and id
      rec_nxt.valid    = 1'b1;
      rec_nxt.delay    = ctl.load_delay;
      rec_nxt.interval = ctl.load_interval;
    end else if (ctl.shift) begin
      rec_nxt = from_nbr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.valid    <= 1'b0;
      rec_r.delay    <= '0;
      rec_r.interval <= '0;
      rec_r.runs     <= '0;
      rec_r.id       <= home_id;
    end else begin
      rec_r <= rec_nxt;
    end
  end

  assign rec = rec_r;

endmodule

// ===== rtl/core/cts_ctrl.sv =====
// cts_ctrl: sequencer for the scheduler ring
// runs ticks and dispatches at the head cell, handles adds, prescaler and result register
// depends on cts_pkg
module cts_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cts_pkg::DIV_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cts_pkg::in_word_t                 in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cts_pkg::out_word_t                out_word,
  input  cts_pkg::slot_rec_t                head,
  output cts_pkg::ring_ctl_t                ctl,
  output logic [cts_pkg::SLOT_COUNT-1:0]    load_en
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_DISP,
    ST_FLUSH
  } state_t;

  localparam logic [cts_pkg::SLOT_W-1:0] K_LAST = cts_pkg::SLOT_W'(cts_pkg::SLOT_COUNT - 1);
  localparam logic [cts_pkg::FILL_W-1:0] FILL_MAX = cts_pkg::FILL_W'(cts_pkg::SLOT_COUNT);

  state_t                          state_r, state_nxt;
  logic [cts_pkg::SLOT_W-1:0]      k_r, k_nxt;
  logic [cts_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [cts_pkg::DIV_W-1:0]       div_r, div_nxt;
  logic [cts_pkg::DIV_W-1:0]       presc_r, presc_nxt;
  logic [cts_pkg::DELAY_W-1:0]     add_delay_r, add_delay_nxt;
  logic [cts_pkg::DELAY_W-1:0]     add_period_r, add_period_nxt;
  logic                            held_valid_r, held_valid_nxt;
  logic [cts_pkg::SLOT_W-1:0]      held_id_r, held_id_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cts_pkg::out_word_t              out_word_r, out_word_nxt;

  logic                            accept;
  logic                            out_free;
  logic                            emit;
  cts_pkg::out_word_t              emit_word;
  logic                            hit;
  logic                            add_ok;
  logic [cts_pkg::SLOT_W+2:0]      held_ext;
  logic [cts_pkg::FILL_W+2:0]      fill_ext;
  cts_pkg::slot_rec_t              head_tick;
  cts_pkg::slot_rec_t              head_disp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign hit      = head.valid && (head.runs != '0);
  assign add_ok   = (fill_r < FILL_MAX);
  assign held_ext = {3'b000, held_id_r};
  assign fill_ext = {3'b000, fill_r};

  // tick update of the record at the head
  always_comb begin
    head_tick = head;
    if (head.valid) begin
      if (head.delay == '0) begin
        if (head.runs != cts_pkg::RUNS_MAX) begin
          head_tick.runs = head.runs + 1'b1;
        end
        if (head.interval != '0) begin
          head_tick.delay = head.interval;
        end
      end else begin
        head_tick.delay = head.delay - 1'b1;
      end
    end
  end

  always_comb begin
    head_disp = head;
    if (hit) begin
      head_disp.runs = head.runs - 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    fill_nxt       = fill_r;
    div_nxt        = div_r;
    presc_nxt      = presc_r;
    add_delay_nxt  = add_delay_r;
    add_period_nxt = add_period_r;
    held_valid_nxt = held_valid_r;
    held_id_nxt    = held_id_r;
    emit           = 1'b0;
    emit_word      = '0;
    ctl.shift         = 1'b0;
    ctl.head_rec      = head;
    ctl.load_delay    = add_delay_r;
    ctl.load_interval = add_period_r;
    load_en        = '0;

    if (cfg_we) begin
      div_nxt = cfg_wdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_word.command)
            cts_pkg::CMD_OVERFLOW: begin
              if (presc_r >= div_r) begin
                presc_nxt = '0;
                k_nxt     = '0;
                state_nxt = ST_TICK;
              end else begin
                presc_nxt = presc_r + 1'b1;
              end
            end
            cts_pkg::CMD_ADD: begin
              add_delay_nxt  = in_word.start_delay;
              add_period_nxt = in_word.period;
              state_nxt      = ST_ADD;
            end
            cts_pkg::CMD_DISPATCH: begin
              k_nxt          = '0;
              held_valid_nxt = 1'b0;
              state_nxt      = ST_DISP;
            end
            default: ;
          endcase
        end
      end
      ST_ADD: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_word.last = 1'b1;
          if (add_ok) begin
            emit_word.kind = cts_pkg::KIND_ADD_OK;
            emit_word.slot = fill_ext[2:0];
            for (int i = 0; i < cts_pkg::SLOT_COUNT; i++) begin
              load_en[i] = (fill_r == cts_pkg::FILL_W'(i));
            end
            fill_nxt = fill_r + 1'b1;
          end else begin
            emit_word.kind = cts_pkg::KIND_ADD_FULL;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK: begin
        ctl.shift    = 1'b1;
        ctl.head_rec = head_tick;
        k_nxt        = k_r + 1'b1;
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_DISP: begin
        // a second hit pushes out the held one, which is then known not to be last
        if (!(hit && held_valid_r) || out_free) begin
          ctl.shift    = 1'b1;
          ctl.head_rec = head_disp;
          k_nxt        = k_r + 1'b1;
          if (hit) begin
            if (held_valid_r) begin
              emit           = 1'b1;
              emit_word.kind = cts_pkg::KIND_RUN;
              emit_word.slot = held_ext[2:0];
              emit_word.last = 1'b0;
            end
            held_valid_nxt = 1'b1;
            held_id_nxt    = head.id;
          end
          if (k_r == K_LAST) begin
            k_nxt     = '0;
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_word.last = 1'b1;
          if (held_valid_r) begin
            emit_word.kind = cts_pkg::KIND_RUN;
            emit_word.slot = held_ext[2:0];
          end else begin
            emit_word.kind = cts_pkg::KIND_NONE;
          end
          held_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = emit_word;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      fill_r       <= '0;
      div_r        <= '0;
      presc_r      <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      fill_r       <= fill_nxt;
      div_r        <= div_nxt;
      presc_r      <= presc_nxt;
      held_valid_r <= held_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    add_delay_r  <= add_delay_nxt;
    add_period_r <= add_period_nxt;
    held_id_r    <= held_id_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_load_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(load_en))
    else $error("more than one slot loaded");

  a_load_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en != '0) |-> (state_r == ST_ADD && !ctl.shift))
    else $error("slot load outside add");

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_ADD || state_r == ST_FLUSH) |-> (k_r == '0))
    else $error("ring not at home position");

  a_held_scope: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (state_r == ST_DISP || state_r == ST_FLUSH))
    else $error("held run outside dispatch");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count beyond table");

endmodule

// ===== rtl/core/cooperative_task_scheduler.sv =====
// cooperative_task_scheduler: time-triggered cooperative scheduler, top level
// a ring of cts_cell slots rotated past the head by cts_ctrl
// depends on cts_pkg, cts_cell, cts_ctrl
//
//   port group  | dir | handshake          | word
//   in_         | in  | in_valid/in_stall  | in_word  (command, start_delay, period)
//   out_        | out | out_valid/out_stall| out_word (kind, slot, last)
//   cfg_        | in  | cfg_we             | cfg_wdata (overflow_divider)
//
// overflow: counts the prescaler, or on reaching the divider ticks and the ring rotates once
// add: accept, then load and result; dispatch: accept, rotation past the head, flush
// one word at a time; in_stall is high while a word is being worked on
// out_stall holds the result register and, when it must be refilled, the rotation
// rst_n is synchronous: table, fill count, prescaler and divider clear
module cooperative_task_scheduler (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cts_pkg::DIV_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cts_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cts_pkg::out_word_t           out_word
);

  cts_pkg::slot_rec_t                 rec [cts_pkg::SLOT_COUNT];
  cts_pkg::slot_rec_t                 nbr [cts_pkg::SLOT_COUNT];
  cts_pkg::ring_ctl_t                 ctl;
  logic [cts_pkg::SLOT_COUNT-1:0]     load_en;

  cts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .head      (rec[0]),
    .ctl       (ctl),
    .load_en   (load_en)
  );

  for (genvar gi = 0; gi < cts_pkg::SLOT_COUNT; gi++) begin : g_cell
    // processed head record wraps to the tail
    if (gi == cts_pkg::SLOT_COUNT - 1) begin : g_tail
      assign nbr[gi] = ctl.head_rec;
    end else begin : g_mid
      assign nbr[gi] = rec[gi+1];
    end

    cts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .home_id  (cts_pkg::SLOT_W'(gi)),
      .ctl      (ctl),
      .load_en  (load_en[gi]),
      .from_nbr (nbr[gi]),
      .rec      (rec[gi])
    );
  end

endmodule
